@@ rtl/itok_pkg.sv @@
// ----------------------------------------------------------------------------
// itok_pkg
// Shared widths, character codes, token kinds and the descriptor that the
// front hands to the back through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package itok_pkg;

  localparam int MAX_INDENT  = 15;
  localparam int LINE_BITS   = 16;
  localparam int OFFSET_BITS = 24;
  localparam int INDENT_BITS = $clog2(MAX_INDENT + 1);
  localparam int KIND_BITS   = 4;
  localparam int CHAR_BITS   = 8;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic [LINE_BITS-1:0]   LINE_ONE   = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0]   LINE_TOP   = {LINE_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] OFF_ONE    = OFFSET_BITS'(1);
  localparam logic [INDENT_BITS-1:0] IND_ONE    = INDENT_BITS'(1);
  localparam logic [INDENT_BITS-1:0] IND_TOP    = INDENT_BITS'(MAX_INDENT);
  localparam logic [Q_PTR_BITS-1:0]  Q_PTR_ONE  = Q_PTR_BITS'(1);
  localparam logic [Q_PTR_BITS-1:0]  Q_PTR_LAST = Q_PTR_BITS'(Q_DEPTH - 1);
  localparam logic [Q_CNT_BITS-1:0]  Q_CNT_ONE  = Q_CNT_BITS'(1);
  localparam logic [Q_CNT_BITS-1:0]  Q_FULL     = Q_CNT_BITS'(Q_DEPTH);

  // character codes
  localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_LF     = 8'h0a;
  localparam logic [CHAR_BITS-1:0] CH_VT     = 8'h0b;
  localparam logic [CHAR_BITS-1:0] CH_FF     = 8'h0c;
  localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0d;
  localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_BITS-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_BITS-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_BITS-1:0] CH_COMMA  = 8'h2c;
  localparam logic [CHAR_BITS-1:0] CH_LCURLY = 8'h7b;
  localparam logic [CHAR_BITS-1:0] CH_RCURLY = 8'h7d;

  // token kinds
  localparam logic [KIND_BITS-1:0] K_INDENT    = 4'd0;
  localparam logic [KIND_BITS-1:0] K_DEDENT    = 4'd1;
  localparam logic [KIND_BITS-1:0] K_NEWLINE   = 4'd2;
  localparam logic [KIND_BITS-1:0] K_LPAREN    = 4'd3;
  localparam logic [KIND_BITS-1:0] K_RPAREN    = 4'd4;
  localparam logic [KIND_BITS-1:0] K_LCURLY    = 4'd5;
  localparam logic [KIND_BITS-1:0] K_RCURLY    = 4'd6;
  localparam logic [KIND_BITS-1:0] K_COMMA     = 4'd7;
  localparam logic [KIND_BITS-1:0] K_COMPONENT = 4'd8;
  localparam logic [KIND_BITS-1:0] K_STRING    = 4'd9;
  localparam logic [KIND_BITS-1:0] K_TEXT      = 4'd10;

  // tokens caused by one character, in output order:
  // dedents, token a, indents, token b
  typedef struct packed {
    logic                   a_valid;
    logic [KIND_BITS-1:0]   a_kind;
    logic [LINE_BITS-1:0]   a_line;
    logic [LINE_BITS-1:0]   a_column;
    logic [OFFSET_BITS-1:0] a_begin;
    logic [OFFSET_BITS-1:0] a_end;
    logic [INDENT_BITS-1:0] dedents;
    logic [INDENT_BITS-1:0] indents;
    logic [LINE_BITS-1:0]   cur_line;
    logic [LINE_BITS-1:0]   cur_column;
    logic                   b_valid;
    logic [KIND_BITS-1:0]   b_kind;
    logic [OFFSET_BITS-1:0] b_pos;
  } desc_t;

  function automatic logic [LINE_BITS-1:0] sat_inc(input logic [LINE_BITS-1:0] v);
    return (v == LINE_TOP) ? v : v + LINE_ONE;
  endfunction

endpackage

`default_nettype wire

@@ rtl/itok_char_if.sv @@
// ----------------------------------------------------------------------------
// itok_char_if
// Character channel: one input character per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface itok_char_if;
  logic                           valid;
  logic                           ready;
  logic [itok_pkg::CHAR_BITS-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

`default_nettype wire

@@ rtl/itok_token_if.sv @@
// ----------------------------------------------------------------------------
// itok_token_if
// Token channel: one token per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface itok_token_if;
  logic                             valid;
  logic                             ready;
  logic [itok_pkg::KIND_BITS-1:0]   token_kind;
  logic [itok_pkg::LINE_BITS-1:0]   token_line;
  logic [itok_pkg::LINE_BITS-1:0]   token_column;
  logic [itok_pkg::OFFSET_BITS-1:0] text_begin;
  logic [itok_pkg::OFFSET_BITS-1:0] text_end;
  logic                             last_of_run;

  modport source (output valid, output token_kind, output token_line,
                  output token_column, output text_begin, output text_end,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_line,
                input token_column, input text_begin, input text_end,
                input last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/indent_aware_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// indent_aware_tokenizer_core
// Streaming lexer for an indentation-sensitive text format: characters in,
// tokens with kind, line, column and byte offsets out.
// ----------------------------------------------------------------------------
//  port    dir  word                          handshake
//  chars   in   char_code (8)                 valid / ready
//  tokens  out  kind, line, column, begin,    valid / ready
//               end, last_of_run
//
// the front takes one character per cycle while the descriptor queue
// (4 entries) has room; the back drives one token per cycle unless tokens
// stalls, and a character holds the back until all its tokens are out (a
// newline with k indent changes and a trailing bracket causes k + 2 tokens)
// the control state is cleared by synchronous rst (held positions and queue
// entries are not); no clearing pass, chars.ready is high right after reset
// a stalled token output fills the queue and then drops chars.ready
// ----------------------------------------------------------------------------
`default_nettype none

module indent_aware_tokenizer_core (
  input  wire logic     clk,
  input  wire logic     rst,
  itok_char_if.sink     chars,
  itok_token_if.source  tokens
);

  itok_pkg::desc_t q_wdata;
  itok_pkg::desc_t q_head;
  logic            q_write;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;

  itok_front u_front (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .q_full  (q_full),
    .q_write (q_write),
    .q_data  (q_wdata)
  );

  itok_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .write (q_write),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty)
  );

  itok_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .empty  (q_empty),
    .pop    (q_pop),
    .tokens (tokens)
  );

endmodule

`default_nettype wire

@@ rtl/itok_front.sv @@
// ----------------------------------------------------------------------------
// itok_front
// Takes one character per cycle while the queue has room, runs the lexer state
// and writes a descriptor of the tokens that the character completes into it.
// ----------------------------------------------------------------------------
`default_nettype none

module itok_front (
  input  wire logic            clk,
  input  wire logic            rst,
  itok_char_if.sink            chars,
  input  wire logic            q_full,
  output logic                 q_write,
  output itok_pkg::desc_t      q_data
);

  localparam logic [2:0] M_NORMAL  = 3'd0;
  localparam logic [2:0] M_COMMENT = 3'd1;
  localparam logic [2:0] M_STRING  = 3'd2;
  localparam logic [2:0] M_TEXT    = 3'd3;
  localparam logic [2:0] M_CR      = 3'd4;
  localparam logic [2:0] M_TABS    = 3'd5;

  localparam int LB = itok_pkg::LINE_BITS;
  localparam int OB = itok_pkg::OFFSET_BITS;
  localparam int IB = itok_pkg::INDENT_BITS;

  logic [2:0]    mode, mode_next;
  logic [IB-1:0] indent, indent_next;
  logic [IB-1:0] tabs, tabs_next;
  logic [LB-1:0] line, line_next;
  logic [LB-1:0] column, column_next;
  logic [OB-1:0] pos, pos_next;
  logic          open_comp, open_comp_next;
  logic [OB-1:0] open_begin, open_begin_next;
  logic [LB-1:0] open_line, open_line_next;
  logic [LB-1:0] open_column, open_column_next;
  logic [OB-1:0] pend_begin, pend_begin_next;
  logic [OB-1:0] pend_end, pend_end_next;
  logic [LB-1:0] pend_line, pend_line_next;
  logic [LB-1:0] pend_column, pend_column_next;

  itok_pkg::desc_t d;
  logic            run_normal;
  logic            do_resolve;
  logic [itok_pkg::CHAR_BITS-1:0] c;
  logic            accept;

  function automatic logic is_delim(input logic [itok_pkg::CHAR_BITS-1:0] ch);
    return ch == itok_pkg::CH_SPACE  || ch == itok_pkg::CH_FF     ||
           ch == itok_pkg::CH_VT     || ch == itok_pkg::CH_TAB    ||
           ch == itok_pkg::CH_CR     || ch == itok_pkg::CH_LF     ||
           ch == itok_pkg::CH_LPAREN || ch == itok_pkg::CH_RPAREN ||
           ch == itok_pkg::CH_LCURLY || ch == itok_pkg::CH_RCURLY ||
           ch == itok_pkg::CH_COMMA  || ch == itok_pkg::CH_DOLLAR ||
           ch == itok_pkg::CH_QUOTE;
  endfunction

  assign c           = chars.char_code;
  assign chars.ready = !q_full;
  assign accept      = chars.valid && !q_full;

  always_comb begin
    mode_next        = mode;
    indent_next      = indent;
    tabs_next        = tabs;
    line_next        = line;
    column_next      = column;
    open_comp_next   = open_comp;
    open_begin_next  = open_begin;
    open_line_next   = open_line;
    open_column_next = open_column;
    pend_begin_next  = pend_begin;
    pend_end_next    = pend_end;
    pend_line_next   = pend_line;
    pend_column_next = pend_column;
    pos_next         = pos + itok_pkg::OFF_ONE;
    d                = '0;
    run_normal       = 1'b0;
    do_resolve       = 1'b0;

    if (c == itok_pkg::CH_NUL) begin
      if (mode == M_TEXT || mode == M_STRING) begin
        d.a_valid  = 1'b1;
        d.a_kind   = (mode == M_STRING) ? itok_pkg::K_STRING :
                     (open_comp ? itok_pkg::K_COMPONENT : itok_pkg::K_TEXT);
        d.a_line   = open_line;
        d.a_column = open_column;
        d.a_begin  = open_begin;
        d.a_end    = pos;
      end else if (mode == M_CR || mode == M_TABS) begin
        do_resolve = 1'b1;
      end
    end else begin
      case (mode)
        M_COMMENT: begin
          if (c == itok_pkg::CH_CR || c == itok_pkg::CH_LF) begin
            mode_next  = M_NORMAL;
            run_normal = 1'b1;
          end else begin
            column_next = itok_pkg::sat_inc(column);
          end
        end
        M_STRING: begin
          if (c == itok_pkg::CH_QUOTE) begin
            d.a_valid  = 1'b1;
            d.a_kind   = itok_pkg::K_STRING;
            d.a_line   = open_line;
            d.a_column = open_column;
            d.a_begin  = open_begin;
            d.a_end    = pos;
            mode_next  = M_NORMAL;
          end
          column_next = itok_pkg::sat_inc(column);
        end
        M_TEXT: begin
          if (is_delim(c)) begin
            d.a_valid  = 1'b1;
            d.a_kind   = open_comp ? itok_pkg::K_COMPONENT : itok_pkg::K_TEXT;
            d.a_line   = open_line;
            d.a_column = open_column;
            d.a_begin  = open_begin;
            d.a_end    = pos;
            mode_next  = M_NORMAL;
            run_normal = 1'b1;
          end else begin
            column_next = itok_pkg::sat_inc(column);
          end
        end
        M_CR: begin
          tabs_next = '0;
          mode_next = M_TABS;
          if (c == itok_pkg::CH_LF) begin
            pend_end_next = pos + itok_pkg::OFF_ONE;
          end else if (c == itok_pkg::CH_TAB) begin
            tabs_next   = itok_pkg::IND_ONE;
            column_next = itok_pkg::sat_inc(column);
          end else begin
            do_resolve = 1'b1;
            run_normal = 1'b1;
          end
        end
        M_TABS: begin
          if (c == itok_pkg::CH_TAB) begin
            if (tabs < itok_pkg::IND_TOP) begin
              tabs_next = tabs + itok_pkg::IND_ONE;
            end
            column_next = itok_pkg::sat_inc(column);
          end else begin
            do_resolve = 1'b1;
            run_normal = 1'b1;
          end
        end
        default: begin
          mode_next  = M_NORMAL;
          run_normal = 1'b1;
        end
      endcase
    end

    // pending newline with the indent change of the new line
    if (do_resolve) begin
      d.a_valid   = 1'b1;
      d.a_kind    = itok_pkg::K_NEWLINE;
      d.a_line    = pend_line;
      d.a_column  = pend_column;
      d.a_begin   = pend_begin;
      d.a_end     = pend_end;
      d.dedents   = (indent > tabs_next) ? indent - tabs_next : '0;
      d.indents   = (tabs_next > indent) ? tabs_next - indent : '0;
      indent_next = tabs_next;
      tabs_next   = '0;
      mode_next   = M_NORMAL;
    end

    d.cur_line   = line_next;
    d.cur_column = column_next;
    d.b_pos      = pos;

    if (run_normal) begin
      case (c)
        itok_pkg::CH_SPACE, itok_pkg::CH_FF, itok_pkg::CH_VT, itok_pkg::CH_TAB: begin
          column_next = itok_pkg::sat_inc(column_next);
        end
        itok_pkg::CH_HASH: begin
          column_next = itok_pkg::sat_inc(column_next);
          mode_next   = M_COMMENT;
        end
        itok_pkg::CH_CR, itok_pkg::CH_LF: begin
          pend_begin_next  = pos;
          pend_end_next    = pos + itok_pkg::OFF_ONE;
          pend_line_next   = line_next;
          pend_column_next = column_next;
          line_next        = itok_pkg::sat_inc(line_next);
          column_next      = '0;
          tabs_next        = '0;
          mode_next        = (c == itok_pkg::CH_CR) ? M_CR : M_TABS;
        end
        itok_pkg::CH_QUOTE, itok_pkg::CH_DOLLAR: begin
          open_begin_next  = pos + itok_pkg::OFF_ONE;
          open_line_next   = line_next;
          open_column_next = column_next;
          open_comp_next   = (c == itok_pkg::CH_DOLLAR);
          column_next      = itok_pkg::sat_inc(column_next);
          mode_next        = (c == itok_pkg::CH_DOLLAR) ? M_TEXT : M_STRING;
        end
        itok_pkg::CH_LPAREN: begin
          d.b_valid   = 1'b1;
          d.b_kind    = itok_pkg::K_LPAREN;
          column_next = itok_pkg::sat_inc(column_next);
        end
        itok_pkg::CH_RPAREN: begin
          d.b_valid   = 1'b1;
          d.b_kind    = itok_pkg::K_RPAREN;
          column_next = itok_pkg::sat_inc(column_next);
        end
        itok_pkg::CH_LCURLY: begin
          d.b_valid   = 1'b1;
          d.b_kind    = itok_pkg::K_LCURLY;
          column_next = itok_pkg::sat_inc(column_next);
        end
        itok_pkg::CH_RCURLY: begin
          d.b_valid   = 1'b1;
          d.b_kind    = itok_pkg::K_RCURLY;
          column_next = itok_pkg::sat_inc(column_next);
        end
        itok_pkg::CH_COMMA: begin
          d.b_valid   = 1'b1;
          d.b_kind    = itok_pkg::K_COMMA;
          column_next = itok_pkg::sat_inc(column_next);
        end
        default: begin
          open_begin_next  = pos;
          open_line_next   = line_next;
          open_column_next = column_next;
          open_comp_next   = 1'b0;
          column_next      = itok_pkg::sat_inc(column_next);
          mode_next        = M_TEXT;
        end
      endcase
    end

    // end of input: back to the reset state
    if (c == itok_pkg::CH_NUL) begin
      mode_next      = M_NORMAL;
      indent_next    = '0;
      tabs_next      = '0;
      line_next      = itok_pkg::LINE_ONE;
      column_next    = '0;
      pos_next       = '0;
      open_comp_next = 1'b0;
    end
  end

  assign q_data  = d;
  assign q_write = accept && (d.a_valid || d.b_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_NORMAL;
      indent    <= '0;
      tabs      <= '0;
      line      <= itok_pkg::LINE_ONE;
      column    <= '0;
      pos       <= '0;
      open_comp <= 1'b0;
    end else if (accept) begin
      mode      <= mode_next;
      indent    <= indent_next;
      tabs      <= tabs_next;
      line      <= line_next;
      column    <= column_next;
      pos       <= pos_next;
      open_comp <= open_comp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      open_begin  <= open_begin_next;
      open_line   <= open_line_next;
      open_column <= open_column_next;
      pend_begin  <= pend_begin_next;
      pend_end    <= pend_end_next;
      pend_line   <= pend_line_next;
      pend_column <= pend_column_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/itok_queue.sv @@
// ----------------------------------------------------------------------------
// itok_queue
// Short first-in first-out queue of token descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module itok_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             write,
  input  wire itok_pkg::desc_t  wdata,
  output logic                  full,
  input  wire logic             pop,
  output itok_pkg::desc_t       head,
  output logic                  empty
);

  itok_pkg::desc_t entries [itok_pkg::Q_DEPTH];

  logic [itok_pkg::Q_PTR_BITS-1:0] wr_ptr, wr_ptr_next;
  logic [itok_pkg::Q_PTR_BITS-1:0] rd_ptr, rd_ptr_next;
  logic [itok_pkg::Q_CNT_BITS-1:0] count;
  logic                            do_write;
  logic                            do_pop;

  assign full     = (count == itok_pkg::Q_FULL);
  assign empty    = (count == '0);
  assign do_write = write && !full;
  assign do_pop   = pop && !empty;
  assign head     = entries[rd_ptr];

  assign wr_ptr_next = (wr_ptr == itok_pkg::Q_PTR_LAST) ? '0 : wr_ptr + itok_pkg::Q_PTR_ONE;
  assign rd_ptr_next = (rd_ptr == itok_pkg::Q_PTR_LAST) ? '0 : rd_ptr + itok_pkg::Q_PTR_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_write) begin
        wr_ptr <= wr_ptr_next;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr_next;
      end
      if (do_write && !do_pop) begin
        count <= count + itok_pkg::Q_CNT_ONE;
      end else if (do_pop && !do_write) begin
        count <= count - itok_pkg::Q_CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ rtl/itok_back.sv @@
// ----------------------------------------------------------------------------
// itok_back
// Expands the head descriptor into the output register, one token per cycle
// unless stalled: dedents, first token, indents, then the single-character token.
// ----------------------------------------------------------------------------
`default_nettype none

module itok_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire itok_pkg::desc_t  head,
  input  wire logic             empty,
  output logic                  pop,
  itok_token_if.source          tokens
);

  localparam logic PH_DED = 1'b0;
  localparam logic PH_IND = 1'b1;

  localparam int IB = itok_pkg::INDENT_BITS;

  logic          phase, phase_next;
  logic [IB-1:0] cnt, cnt_next;
  logic          fire;
  logic          last;

  logic [itok_pkg::KIND_BITS-1:0]   kind;
  logic [itok_pkg::LINE_BITS-1:0]   tline;
  logic [itok_pkg::LINE_BITS-1:0]   tcolumn;
  logic [itok_pkg::OFFSET_BITS-1:0] tbegin;
  logic [itok_pkg::OFFSET_BITS-1:0] tend;
  logic [IB:0]                      cnt_inc;

  assign fire    = !empty && (!tokens.valid || tokens.ready);
  assign pop     = fire && last;
  assign cnt_inc = {1'b0, cnt} + {{IB{1'b0}}, 1'b1};

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    kind       = head.b_kind;
    tline      = head.cur_line;
    tcolumn    = head.cur_column;
    tbegin     = head.b_pos;
    tend       = head.b_pos + itok_pkg::OFF_ONE;
    last       = 1'b1;

    if (phase == PH_DED && cnt < head.dedents) begin
      kind     = itok_pkg::K_DEDENT;
      tbegin   = '0;
      tend     = '0;
      cnt_next = cnt + itok_pkg::IND_ONE;
      last     = (cnt_inc == {1'b0, head.dedents}) && !head.a_valid &&
                 (head.indents == '0) && !head.b_valid;
    end else if (phase == PH_DED && head.a_valid) begin
      kind       = head.a_kind;
      tline      = head.a_line;
      tcolumn    = head.a_column;
      tbegin     = head.a_begin;
      tend       = head.a_end;
      phase_next = PH_IND;
      cnt_next   = '0;
      last       = (head.indents == '0) && !head.b_valid;
    end else if (phase == PH_IND && cnt < head.indents) begin
      kind     = itok_pkg::K_INDENT;
      tbegin   = '0;
      tend     = '0;
      cnt_next = cnt + itok_pkg::IND_ONE;
      last     = (cnt_inc == {1'b0, head.indents}) && !head.b_valid;
    end

    // next descriptor starts from the top
    if (last) begin
      phase_next = PH_DED;
      cnt_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DED;
      cnt          <= '0;
      tokens.valid <= 1'b0;
    end else begin
      if (fire) begin
        phase        <= phase_next;
        cnt          <= cnt_next;
        tokens.valid <= 1'b1;
      end else if (tokens.ready) begin
        tokens.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tokens.token_kind   <= kind;
      tokens.token_line   <= tline;
      tokens.token_column <= tcolumn;
      tokens.text_begin   <= tbegin;
      tokens.text_end     <= tend;
      tokens.last_of_run  <= last;
    end
  end

endmodule

`default_nettype wire

@@ tb/indent_aware_tokenizer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indent_aware_tokenizer_core_tb
// Feeds character streams into the tokenizer and checks every token word
// against a cycle-free predictor of the lexer kept inside this bench. The
// directed tests cover each token kind, line breaks, indent changes and end of
// input. The random tests send mostly well-formed lines with random content.
// ----------------------------------------------------------------------------
module indent_aware_tokenizer_core_tb;
  import itok_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 32;
  localparam int MAX_SHOWN    = 10;

  typedef enum logic [2:0] {
    LX_NORMAL, LX_COMMENT, LX_STRING, LX_TEXT, LX_CR, LX_TABS
  } lex_mode_e;

  typedef struct packed {
    logic [KIND_BITS-1:0]   kind;
    logic [LINE_BITS-1:0]   line;
    logic [LINE_BITS-1:0]   column;
    logic [OFFSET_BITS-1:0] beg_off;
    logic [OFFSET_BITS-1:0] end_off;
    logic                   last;
  } token_t;

  logic clk = 1'b0;
  logic rst;

  itok_char_if  chars_if ();
  itok_token_if tokens_if ();

  indent_aware_tokenizer_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .tokens (tokens_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // lexer state as the predictor sees it
  lex_mode_e              lx_mode;
  logic [INDENT_BITS-1:0] kept_depth;
  logic [INDENT_BITS-1:0] lead_tabs;
  logic [LINE_BITS-1:0]   cur_line;
  logic [LINE_BITS-1:0]   cur_col;
  logic [OFFSET_BITS-1:0] byte_pos;
  logic [OFFSET_BITS-1:0] open_first;
  logic [LINE_BITS-1:0]   open_line;
  logic [LINE_BITS-1:0]   open_col;
  logic                   open_comp;
  logic [OFFSET_BITS-1:0] nl_first;
  logic [OFFSET_BITS-1:0] nl_stop;
  logic [LINE_BITS-1:0]   nl_line;
  logic [LINE_BITS-1:0]   nl_col;

  token_t expected_tokens[$];
  int     mismatch_cnt = 0;
  int     sent_items = 0;
  int     cycle_cnt = 0;
  int     sink_wait = 0;
  logic   token_taken = 1'b0;
  logic   no_gaps = 1'b0;

  function automatic logic [LINE_BITS-1:0] sat_bump(input logic [LINE_BITS-1:0] v);
    return (v == LINE_TOP) ? v : v + LINE_ONE;
  endfunction

  function automatic bit is_delim(input logic [CHAR_BITS-1:0] c);
    return c inside {CH_SPACE, CH_FF, CH_VT, CH_TAB, CH_CR, CH_LF, CH_LPAREN,
                     CH_RPAREN, CH_LCURLY, CH_RCURLY, CH_COMMA, CH_DOLLAR, CH_QUOTE};
  endfunction

  function automatic void clear_lexer();
    lx_mode    = LX_NORMAL;
    kept_depth = '0;
    lead_tabs  = '0;
    cur_line   = LINE_ONE;
    cur_col    = '0;
    byte_pos   = '0;
    open_first = '0;
    open_line  = '0;
    open_col   = '0;
    open_comp  = 1'b0;
    nl_first   = '0;
    nl_stop    = '0;
    nl_line    = '0;
    nl_col     = '0;
  endfunction

  function automatic void put_token(input logic [KIND_BITS-1:0] kind,
                                    input logic [LINE_BITS-1:0] ln,
                                    input logic [LINE_BITS-1:0] col,
                                    input logic [OFFSET_BITS-1:0] first,
                                    input logic [OFFSET_BITS-1:0] stop);
    token_t t;
    t.kind    = kind;
    t.line    = ln;
    t.column  = col;
    t.beg_off = first;
    t.end_off = stop;
    t.last    = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  // dedents go before the held newline, indents after it
  function automatic void close_newline();
    int k;
    for (k = int'(lead_tabs); k < int'(kept_depth); k++)
      put_token(K_DEDENT, cur_line, cur_col, '0, '0);
    put_token(K_NEWLINE, nl_line, nl_col, nl_first, nl_stop);
    for (k = int'(kept_depth); k < int'(lead_tabs); k++)
      put_token(K_INDENT, cur_line, cur_col, '0, '0);
    kept_depth = lead_tabs;
    lead_tabs  = '0;
    lx_mode    = LX_NORMAL;
  endfunction

  function automatic void start_token(input logic [OFFSET_BITS-1:0] first,
                                      input logic comp, input lex_mode_e mode);
    open_first = first;
    open_line  = cur_line;
    open_col   = cur_col;
    open_comp  = comp;
    cur_col    = sat_bump(cur_col);
    lx_mode    = mode;
  endfunction

  function automatic void punct_token(input logic [KIND_BITS-1:0] kind,
                                      input logic [OFFSET_BITS-1:0] pos);
    put_token(kind, cur_line, cur_col, pos, pos + OFF_ONE);
    cur_col = sat_bump(cur_col);
  endfunction

  function automatic void normal_char(input logic [CHAR_BITS-1:0] c,
                                      input logic [OFFSET_BITS-1:0] pos);
    case (c)
      CH_SPACE, CH_FF, CH_VT, CH_TAB: cur_col = sat_bump(cur_col);
      CH_HASH: begin
        cur_col = sat_bump(cur_col);
        lx_mode = LX_COMMENT;
      end
      CH_CR, CH_LF: begin
        nl_first  = pos;
        nl_stop   = pos + OFF_ONE;
        nl_line   = cur_line;
        nl_col    = cur_col;
        cur_line  = sat_bump(cur_line);
        cur_col   = '0;
        lead_tabs = '0;
        lx_mode   = (c == CH_CR) ? LX_CR : LX_TABS;
      end
      CH_QUOTE:  start_token(pos + OFF_ONE, 1'b0, LX_STRING);
      CH_DOLLAR: start_token(pos + OFF_ONE, 1'b1, LX_TEXT);
      CH_LPAREN: punct_token(K_LPAREN, pos);
      CH_RPAREN: punct_token(K_RPAREN, pos);
      CH_LCURLY: punct_token(K_LCURLY, pos);
      CH_RCURLY: punct_token(K_RCURLY, pos);
      CH_COMMA:  punct_token(K_COMMA, pos);
      default:   start_token(pos, 1'b0, LX_TEXT);
    endcase
  endfunction

  function automatic void tabs_char(input logic [CHAR_BITS-1:0] c,
                                    input logic [OFFSET_BITS-1:0] pos);
    if (c == CH_TAB) begin
      if (lead_tabs < IND_TOP)
        lead_tabs = lead_tabs + IND_ONE;
      cur_col = sat_bump(cur_col);
    end else begin
      close_newline();
      normal_char(c, pos);
    end
  endfunction

  function automatic logic [KIND_BITS-1:0] open_kind();
    if (lx_mode == LX_STRING)
      return K_STRING;
    return open_comp ? K_COMPONENT : K_TEXT;
  endfunction

  // queues the tokens that one accepted character completes
  function automatic void tokenize_char(input logic [CHAR_BITS-1:0] c);
    logic [OFFSET_BITS-1:0] pos;
    int                     n0;
    pos = byte_pos;
    n0  = expected_tokens.size();
    if (c == CH_NUL) begin
      if (lx_mode == LX_TEXT || lx_mode == LX_STRING)
        put_token(open_kind(), open_line, open_col, open_first, pos);
      else if (lx_mode == LX_CR || lx_mode == LX_TABS)
        close_newline();
      clear_lexer();
    end else begin
      case (lx_mode)
        LX_COMMENT: begin
          if (c == CH_CR || c == CH_LF) begin
            lx_mode = LX_NORMAL;
            normal_char(c, pos);
          end else begin
            cur_col = sat_bump(cur_col);
          end
        end
        LX_STRING: begin
          if (c == CH_QUOTE) begin
            put_token(K_STRING, open_line, open_col, open_first, pos);
            lx_mode = LX_NORMAL;
          end
          cur_col = sat_bump(cur_col);
        end
        LX_TEXT: begin
          if (is_delim(c)) begin
            put_token(open_kind(), open_line, open_col, open_first, pos);
            lx_mode = LX_NORMAL;
            normal_char(c, pos);
          end else begin
            cur_col = sat_bump(cur_col);
          end
        end
        LX_CR: begin
          lead_tabs = '0;
          lx_mode   = LX_TABS;
          if (c == CH_LF)
            nl_stop = pos + OFF_ONE;
          else
            tabs_char(c, pos);
        end
        LX_TABS: tabs_char(c, pos);
        default: begin
          lx_mode = LX_NORMAL;
          normal_char(c, pos);
        end
      endcase
      byte_pos = pos + OFF_ONE;
    end
    if (expected_tokens.size() > n0)
      expected_tokens[$].last = 1'b1;
  endfunction

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 17);
  endfunction

  // predict on accepted chars, then check the token word of the same edge
  always @(posedge clk) begin : watch
    token_t got;
    token_t want;
    if (rst) begin
      token_taken = 1'b0;
    end else begin
      if (chars_if.valid && chars_if.ready)
        tokenize_char(chars_if.char_code);
      token_taken = tokens_if.valid && tokens_if.ready;
      if (token_taken) begin
        got.kind    = tokens_if.token_kind;
        got.line    = tokens_if.token_line;
        got.column  = tokens_if.token_column;
        got.beg_off = tokens_if.text_begin;
        got.end_off = tokens_if.text_end;
        got.last    = tokens_if.last_of_run;
        if (expected_tokens.size() == 0) begin
          if (mismatch_cnt < MAX_SHOWN)
            $display("unexpected token: kind %0d line %0d col %0d off %0d..%0d last %0d",
                     got.kind, got.line, got.column, got.beg_off, got.end_off, got.last);
          mismatch_cnt++;
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            if (mismatch_cnt < MAX_SHOWN) begin
              $display("token mismatch at %0t", $realtime);
              $display("  exp kind %0d line %0d col %0d off %0d..%0d last %0d",
                       want.kind, want.line, want.column, want.beg_off, want.end_off,
                       want.last);
              $display("  got kind %0d line %0d col %0d off %0d..%0d last %0d",
                       got.kind, got.line, got.column, got.beg_off, got.end_off,
                       got.last);
            end
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // token side back-pressure, a fresh stall drawn after each word
  initial begin
    tokens_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (token_taken)
        sink_wait = draw_gap();
      if (sink_wait != 0) begin
        sink_wait--;
        tokens_if.ready <= 1'b0;
      end else begin
        tokens_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("status: fail");
    $finish;
  end

  task automatic send_char(input logic [CHAR_BITS-1:0] c);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      chars_if.valid <= 1'b0;
    end
    @(negedge clk);
    chars_if.valid     <= 1'b1;
    chars_if.char_code <= c;
    do @(posedge clk); while (!chars_if.ready);
    sent_items++;
  endtask

  task automatic send_str(input string s);
    foreach (s[i])
      send_char(s[i]);
  endtask

  task automatic wait_for_tokens();
    @(negedge clk);
    chars_if.valid <= 1'b0;
    while (expected_tokens.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic [CHAR_BITS-1:0] word_char();
    logic [CHAR_BITS-1:0] c;
    do c = CHAR_BITS'($urandom_range(1, 255)); while (is_delim(c));
    return c;
  endfunction

  task automatic send_word();
    logic [CHAR_BITS-1:0] c;
    c = word_char();
    if (c == CH_HASH)
      c = "a";
    send_char(c);
    repeat ($urandom_range(0, 5))
      send_char(word_char());
  endtask

  task automatic test_single_tokens();
    send_str("$a(b,\"s\"){}x");
    send_char(8'hff);
    send_char(CH_NUL);
    wait_for_tokens();
  endtask

  // skipped tab and comment, indent by two, crlf with dedent, string over a
  // line break, lone cr
  task automatic test_line_layout();
    send_char(CH_TAB);
    send_str("#q");
    send_char(CH_LF);
    send_char(CH_TAB);
    send_char(CH_TAB);
    send_str("a");
    send_char(CH_VT);
    send_char(CH_CR);
    send_char(CH_LF);
    send_char(CH_FF);
    send_char(CH_QUOTE);
    send_char(CH_LF);
    send_char(CH_QUOTE);
    send_char(CH_CR);
    send_char(CH_RPAREN);
    send_char(CH_NUL);
    wait_for_tokens();
  endtask

  task automatic test_end_of_input();
    send_str("\"k");
    send_char(CH_NUL);
    send_str("a");
    send_char(CH_LF);
    send_char(CH_TAB);
    send_char(CH_NUL);
    send_char(CH_CR);
    send_char(CH_NUL);
    send_char(CH_NUL);
    wait_for_tokens();
  endtask

  task automatic test_random_text(input int item_goal);
    int                   start_cnt;
    int                   tabs;
    logic [CHAR_BITS-1:0] c;
    start_cnt = sent_items;
    while (sent_items - start_cnt < item_goal) begin
      if ($urandom_range(0, 7) == 0)
        no_gaps = !no_gaps;
      if ($urandom_range(0, 15) == 0)
        wait_for_tokens();
      tabs = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : $urandom_range(0, 3);
      repeat (tabs)
        send_char(CH_TAB);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 9))
          0: begin
            send_char(CH_DOLLAR);
            send_word();
          end
          1: begin
            send_char(CH_QUOTE);
            repeat ($urandom_range(0, 4)) begin
              do c = CHAR_BITS'($urandom_range(1, 255)); while (c == CH_QUOTE);
              send_char(c);
            end
            if ($urandom_range(0, 7) != 0)
              send_char(CH_QUOTE);
          end
          2, 3: begin
            case ($urandom_range(0, 4))
              0: send_char(CH_LPAREN);
              1: send_char(CH_RPAREN);
              2: send_char(CH_LCURLY);
              3: send_char(CH_RCURLY);
              default: send_char(CH_COMMA);
            endcase
          end
          4: begin
            case ($urandom_range(0, 3))
              0: send_char(CH_SPACE);
              1: send_char(CH_FF);
              2: send_char(CH_VT);
              default: send_char(CH_TAB);
            endcase
          end
          5: begin
            send_char(CH_HASH);
            repeat ($urandom_range(0, 4)) begin
              do c = CHAR_BITS'($urandom_range(1, 255)); while (c == CH_CR || c == CH_LF);
              send_char(c);
            end
          end
          6: send_char(CHAR_BITS'($urandom_range(0, 255)));
          default: send_word();
        endcase
      end
      case ($urandom_range(0, 15))
        0: send_char(CH_NUL);
        1: ;
        2, 3, 4: send_char(CH_CR);
        5, 6, 7, 8: begin
          send_char(CH_CR);
          send_char(CH_LF);
        end
        default: send_char(CH_LF);
      endcase
    end
    send_char(CH_NUL);
    no_gaps = 1'b0;
    wait_for_tokens();
  endtask

  initial begin
    clear_lexer();
    rst                = 1'b1;
    chars_if.valid     = 1'b0;
    chars_if.char_code = CH_NUL;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_single_tokens();
    test_line_layout();
    test_end_of_input();
    test_random_text(300);
    wait_for_tokens();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && expected_tokens.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
